@@ src/ost_pkg.sv @@
`timescale 1ns / 1ps

package ost_pkg;

	localparam int FUNC_BITS = 3;

	localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 3'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_SORTED = 3'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_ERASE  = 3'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 3'd3;
	localparam logic [FUNC_BITS-1:0] FUNC_GET    = 3'd4;
	localparam logic [FUNC_BITS-1:0] FUNC_SET    = 3'd5;
	localparam logic [FUNC_BITS-1:0] FUNC_FIND   = 3'd6;

	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_UP    = 2'd1;
	localparam logic [1:0] CELL_DOWN  = 2'd2;
	localparam logic [1:0] CELL_WRITE = 2'd3;

	localparam logic [1:0] MATCH_NONE = 2'd0;
	localparam logic [1:0] MATCH_EQ   = 2'd1;
	localparam logic [1:0] MATCH_GE   = 2'd2;
	localparam logic [1:0] MATCH_POS  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] mode;
	} cell_ctl_t;

endpackage

@@ src/ordered_sequence_table_core.sv @@
`timescale 1ns / 1ps

// Ordered table of up to DEPTH items held in a row of cells, one entry per cell.
// A request is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high, and the receiver
// cannot stall it. Insert at a position, erase and set shift or write the cells
// directly and the unused code changes nothing: these go from idle to the execute
// state, which registers done. Sorted insert, get and find compare in every cell,
// then resolve the first hit in a two-level registered pick tree, passing through
// the flag, tree and execute states. Remove repeats compare, pick and one erase
// shift for every deleted entry. A new request may be taken in the done cycle.
// Entry storage needs no clearing after reset.
module ordered_sequence_table_core #(
	parameter int DEPTH     = 256,
	parameter int ITEM_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ost_pkg::FUNC_BITS-1:0] func,
	input  logic [$clog2(DEPTH+1)-1:0]    pos,
	input  logic [ITEM_BITS-1:0]          item_value,
	output logic                          done,
	output logic                          ok,
	output logic [$clog2(DEPTH+1)-1:0]    index_out,
	output logic [ITEM_BITS-1:0]          item_out,
	output logic [$clog2(DEPTH+1)-1:0]    removed,
	output logic [$clog2(DEPTH+1)-1:0]    length
);
	import ost_pkg::*;

	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FLAG  = 3'd1;
	localparam logic [2:0] ST_TREE1 = 3'd2;
	localparam logic [2:0] ST_TREE2 = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;

	localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(DEPTH);

	logic [2:0]           state_q;
	logic [FUNC_BITS-1:0] func_q;
	logic [CNT_BITS-1:0]  pos_q;
	logic [ITEM_BITS-1:0] value_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  removed_q;
	logic                 done_q;
	logic                 ok_q;
	logic [CNT_BITS-1:0]  index_q;
	logic [ITEM_BITS-1:0] item_q;

	cell_ctl_t            ctl;
	logic [CNT_BITS-1:0]  op_pos;
	logic [ITEM_BITS-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]     cell_hit;

	logic                 pick_found;
	logic [IDX_BITS-1:0]  pick_index;
	logic [ITEM_BITS-1:0] pick_item;

	logic                 ex_ok;
	logic [CNT_BITS-1:0]  ex_idx;
	logic [ITEM_BITS-1:0] ex_item;
	logic [CNT_BITS-1:0]  ex_count;
	logic                 ex_again;
	logic [CNT_BITS-1:0]  hit_pos;
	logic                 accept;
	logic                 needs_search;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign hit_pos = CNT_BITS'(pick_index);

	always_comb begin
		case (func)
			FUNC_SORTED, FUNC_REMOVE, FUNC_GET, FUNC_FIND: needs_search = 1'b1;
			default:                                        needs_search = 1'b0;
		endcase
	end

	always_comb begin
		ctl.op   = CELL_HOLD;
		op_pos   = pos_q;
		ex_ok    = 1'b0;
		ex_idx   = '0;
		ex_item  = '0;
		ex_count = count_q;
		ex_again = 1'b0;
		case (func_q)
			FUNC_SORTED:           ctl.mode = MATCH_GE;
			FUNC_REMOVE, FUNC_FIND: ctl.mode = MATCH_EQ;
			FUNC_GET:              ctl.mode = MATCH_POS;
			default:               ctl.mode = MATCH_NONE;
		endcase
		if (state_q == ST_EXEC) begin
			case (func_q)
				FUNC_INSERT: begin
					if (pos_q <= count_q && count_q != FULL) begin
						ctl.op   = CELL_UP;
						ex_ok    = 1'b1;
						ex_idx   = pos_q;
						ex_count = count_q + 1'b1;
					end
				end
				FUNC_SORTED: begin
					op_pos = pick_found ? hit_pos : count_q;
					if (count_q != FULL) begin
						ctl.op   = CELL_UP;
						ex_ok    = 1'b1;
						ex_idx   = op_pos;
						ex_count = count_q + 1'b1;
					end
				end
				FUNC_ERASE: begin
					if (pos_q < count_q) begin
						ctl.op   = CELL_DOWN;
						ex_ok    = 1'b1;
						ex_count = count_q - 1'b1;
					end
				end
				FUNC_REMOVE: begin
					if (pick_found) begin
						ctl.op   = CELL_DOWN;
						op_pos   = hit_pos;
						ex_count = count_q - 1'b1;
						ex_again = 1'b1;
					end else begin
						ex_ok = 1'b1;
					end
				end
				FUNC_GET: begin
					if (pick_found) begin
						ex_ok   = 1'b1;
						ex_item = pick_item;
					end
				end
				FUNC_SET: begin
					if (pos_q < count_q) begin
						ctl.op = CELL_WRITE;
						ex_ok  = 1'b1;
					end
				end
				FUNC_FIND: begin
					if (pick_found) begin
						ex_ok  = 1'b1;
						ex_idx = hit_pos;
					end
				end
				default: begin
				end
			endcase
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [ITEM_BITS-1:0] left_d;
			logic [ITEM_BITS-1:0] right_d;

			if (i == 0) begin : g_first
				assign left_d = value_q;
			end else begin : g_left
				assign left_d = cell_data[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign right_d = cell_data[i];
			end else begin : g_right
				assign right_d = cell_data[i+1];
			end

			ost_cell #(
				.ITEM_BITS(ITEM_BITS),
				.CNT_BITS (CNT_BITS),
				.IDX      (i)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.op_pos    (op_pos),
				.count     (count_q),
				.value     (value_q),
				.left_data (left_d),
				.right_data(right_d),
				.data      (cell_data[i]),
				.hit       (cell_hit[i])
			);
		end
	endgenerate

	ost_pick #(
		.DEPTH    (DEPTH),
		.ITEM_BITS(ITEM_BITS),
		.IDX_BITS (IDX_BITS)
	) u_pick (
		.clk   (clk),
		.arst_n(arst_n),
		.hit   (cell_hit),
		.data  (cell_data),
		.found (pick_found),
		.index (pick_index),
		.item  (pick_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= needs_search ? ST_FLAG : ST_EXEC;
				end
				ST_FLAG:  state_q <= ST_TREE1;
				ST_TREE1: state_q <= ST_TREE2;
				ST_TREE2: state_q <= ST_EXEC;
				ST_EXEC: begin
					count_q <= ex_count;
					if (ex_again) begin
						state_q <= ST_FLAG;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			pos_q     <= pos;
			value_q   <= item_value;
			removed_q <= '0;
		end else if (state_q == ST_EXEC) begin
			if (ex_again) begin
				removed_q <= removed_q + 1'b1;
			end else begin
				ok_q    <= ex_ok;
				index_q <= ex_idx;
				item_q  <= ex_item;
			end
		end
	end

	assign done      = done_q;
	assign ok        = ok_q;
	assign index_out = index_q;
	assign item_out  = item_q;
	assign removed   = removed_q;
	assign length    = count_q;

endmodule

@@ src/ost_cell.sv @@
`timescale 1ns / 1ps

module ost_cell #(
	parameter int ITEM_BITS = 32,
	parameter int CNT_BITS  = 9,
	parameter int IDX       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ost_pkg::cell_ctl_t    ctl,
	input  logic [CNT_BITS-1:0]   op_pos,
	input  logic [CNT_BITS-1:0]   count,
	input  logic [ITEM_BITS-1:0]  value,
	input  logic [ITEM_BITS-1:0]  left_data,
	input  logic [ITEM_BITS-1:0]  right_data,
	output logic [ITEM_BITS-1:0]  data,
	output logic                  hit
);
	import ost_pkg::*;

	localparam logic [CNT_BITS-1:0] MY_IDX = CNT_BITS'(IDX);

	logic [ITEM_BITS-1:0] data_q;
	logic                 hit_s1;
	logic                 in_use;
	logic                 hit_d;

	assign in_use = MY_IDX < count;

	always_comb begin
		case (ctl.mode)
			MATCH_EQ:  hit_d = in_use && (data_q == value);
			MATCH_GE:  hit_d = in_use && (data_q >= value);
			MATCH_POS: hit_d = in_use && (MY_IDX == op_pos);
			default:   hit_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_UP: begin
				if (MY_IDX > op_pos) data_q <= left_data;
				else if (MY_IDX == op_pos) data_q <= value;
			end
			CELL_DOWN: begin
				if (MY_IDX >= op_pos) data_q <= right_data;
			end
			CELL_WRITE: begin
				if (MY_IDX == op_pos) data_q <= value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= hit_d;
		end
	end

	assign data = data_q;
	assign hit  = hit_s1;

endmodule

@@ src/ost_pick.sv @@
`timescale 1ns / 1ps

module ost_pick #(
	parameter int DEPTH     = 256,
	parameter int ITEM_BITS = 32,
	parameter int IDX_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DEPTH-1:0]     hit,
	input  logic [ITEM_BITS-1:0] data [DEPTH],
	output logic                 found,
	output logic [IDX_BITS-1:0]  index,
	output logic [ITEM_BITS-1:0] item
);
	localparam int GB    = ($clog2(DEPTH) + 1) / 2;
	localparam int GROUP = 1 << GB;
	localparam int NG    = (DEPTH + GROUP - 1) / GROUP;
	localparam int NGB   = (NG > 1) ? $clog2(NG) : 1;
	localparam int PAD   = NG * GROUP;

	logic [PAD-1:0]       hit_pad;
	logic [ITEM_BITS-1:0] data_pad [PAD];

	logic                 grp_any_s2  [NG];
	logic [GB-1:0]        grp_idx_s2  [NG];
	logic [ITEM_BITS-1:0] grp_data_s2 [NG];

	logic                 found_s3;
	logic [IDX_BITS-1:0]  index_s3;
	logic [ITEM_BITS-1:0] item_s3;

	genvar c, g;

	generate
		for (c = 0; c < PAD; c++) begin : g_pad
			if (c < DEPTH) begin : g_live
				assign hit_pad[c]  = hit[c];
				assign data_pad[c] = data[c];
			end else begin : g_fill
				assign hit_pad[c]  = 1'b0;
				assign data_pad[c] = '0;
			end
		end
	endgenerate

	generate
		for (g = 0; g < NG; g++) begin : g_grp
			logic                 any_d;
			logic [GB-1:0]        idx_d;
			logic [ITEM_BITS-1:0] data_d;

			always_comb begin
				any_d  = 1'b0;
				idx_d  = '0;
				data_d = '0;
				for (int k = GROUP - 1; k >= 0; k--) begin
					if (hit_pad[g*GROUP + k]) begin
						any_d  = 1'b1;
						idx_d  = GB'(k);
						data_d = data_pad[g*GROUP + k];
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					grp_any_s2[g] <= 1'b0;
				end else begin
					grp_any_s2[g] <= any_d;
				end
			end

			always_ff @(posedge clk) begin
				grp_idx_s2[g]  <= idx_d;
				grp_data_s2[g] <= data_d;
			end
		end
	endgenerate

	logic                 top_any;
	logic [NGB-1:0]       top_grp;
	logic [GB-1:0]        top_local;
	logic [ITEM_BITS-1:0] top_data;

	always_comb begin
		top_any   = 1'b0;
		top_grp   = '0;
		top_local = '0;
		top_data  = '0;
		for (int k = NG - 1; k >= 0; k--) begin
			if (grp_any_s2[k]) begin
				top_any   = 1'b1;
				top_grp   = NGB'(k);
				top_local = grp_idx_s2[k];
				top_data  = grp_data_s2[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_s3 <= 1'b0;
		end else begin
			found_s3 <= top_any;
		end
	end

	always_ff @(posedge clk) begin
		index_s3 <= IDX_BITS'({top_grp, top_local});
		item_s3  <= top_data;
	end

	assign found = found_s3;
	assign index = index_s3;
	assign item  = item_s3;

endmodule

@@ tb/sv/ordered_sequence_table_core_tb.sv @@
`timescale 1ns / 1ps

module ordered_sequence_table_core_tb;
	import ost_pkg::*;

	localparam int TBL_DEPTH = 256;
	localparam int ITEM_W    = 32;
	localparam int IDX_W     = $clog2(TBL_DEPTH + 1);

	localparam logic [FUNC_BITS-1:0] FUNC_NONE = 3'd7;
	localparam logic [ITEM_W-1:0]    ITEM_MAX  = '1;
	localparam logic [ITEM_W-1:0]    FLOOD_VAL = 32'hA5A5_5A5A;

	typedef struct packed {
		logic              ok;
		logic [IDX_W-1:0]  idx;
		logic [ITEM_W-1:0] item;
		logic [IDX_W-1:0]  removed;
		logic [IDX_W-1:0]  len;
	} seq_result_t;

	class seq_table_scoreboard;
		logic [ITEM_W-1:0] cells [TBL_DEPTH];
		int unsigned       count;
		int unsigned       errors;
		seq_result_t       pending_q[$];

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function bit try_insert(int unsigned at, logic [ITEM_W-1:0] v);
			if (at > count || count >= TBL_DEPTH)
				return 1'b0;
			for (int unsigned i = count; i > at; i--)
				cells[i] = cells[i - 1];
			cells[at] = v;
			count++;
			return 1'b1;
		endfunction

		function void note_request(logic [FUNC_BITS-1:0] f, logic [IDX_W-1:0] p,
				logic [ITEM_W-1:0] v);
			seq_result_t r;
			int unsigned at;
			int unsigned w;
			r  = '0;
			at = p;
			case (f)
				FUNC_INSERT: begin
					if (try_insert(at, v)) begin
						r.ok  = 1'b1;
						r.idx = p;
					end
				end
				FUNC_SORTED: begin
					at = count;
					for (int unsigned i = count; i > 0; i--)
						if (cells[i - 1] >= v)
							at = i - 1;
					if (try_insert(at, v)) begin
						r.ok  = 1'b1;
						r.idx = at[IDX_W-1:0];
					end
				end
				FUNC_ERASE: begin
					if (at < count) begin
						for (int unsigned i = at; i + 1 < count; i++)
							cells[i] = cells[i + 1];
						count--;
						r.ok = 1'b1;
					end
				end
				FUNC_REMOVE: begin
					w = 0;
					for (int unsigned i = 0; i < count; i++)
						if (cells[i] != v) begin
							cells[w] = cells[i];
							w++;
						end
					r.removed = IDX_W'(count - w);
					count     = w;
					r.ok      = 1'b1;
				end
				FUNC_GET: begin
					if (at < count) begin
						r.item = cells[at];
						r.ok   = 1'b1;
					end
				end
				FUNC_SET: begin
					if (at < count) begin
						cells[at] = v;
						r.ok      = 1'b1;
					end
				end
				FUNC_FIND: begin
					for (int unsigned i = count; i > 0; i--)
						if (cells[i - 1] == v) begin
							r.ok  = 1'b1;
							r.idx = IDX_W'(i - 1);
						end
				end
				default: ;
			endcase
			r.len = IDX_W'(count);
			pending_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [ITEM_W-1:0] want,
				logic [ITEM_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(seq_result_t got);
			seq_result_t want;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
				return;
			end
			want = pending_q.pop_front();
			compare_field("ok", ITEM_W'(want.ok), ITEM_W'(got.ok));
			compare_field("index_out", ITEM_W'(want.idx), ITEM_W'(got.idx));
			compare_field("item_out", want.item, got.item);
			compare_field("removed", ITEM_W'(want.removed), ITEM_W'(got.removed));
			compare_field("length", ITEM_W'(want.len), ITEM_W'(got.len));
		endfunction
	endclass

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic [FUNC_BITS-1:0] func       = '0;
	logic [IDX_W-1:0]     pos        = '0;
	logic [ITEM_W-1:0]    item_value = '0;
	logic                 busy;
	logic                 done;
	logic                 ok;
	logic [IDX_W-1:0]     index_out;
	logic [ITEM_W-1:0]    item_out;
	logic [IDX_W-1:0]     removed;
	logic [IDX_W-1:0]     length;

	seq_table_scoreboard sb = new();
	int unsigned         burst_left = 0;

	ordered_sequence_table_core #(
		.DEPTH(TBL_DEPTH),
		.ITEM_BITS(ITEM_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.pos(pos),
		.item_value(item_value),
		.done(done),
		.ok(ok),
		.index_out(index_out),
		.item_out(item_out),
		.removed(removed),
		.length(length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{ok: ok, idx: index_out, item: item_out, removed: removed,
				len: length});
	end

	task automatic issue(input logic [FUNC_BITS-1:0] f, input logic [IDX_W-1:0] p,
			input logic [ITEM_W-1:0] v);
		start      <= 1'b1;
		func       <= f;
		pos        <= p;
		item_value <= v;
		do @(posedge clk); while (busy);
		sb.note_request(f, p, v);
	endtask

	task automatic idle(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 10));
		end
	endtask

	task automatic drain();
		idle(1);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ITEM_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return ITEM_MAX;
			2, 3:    return $urandom();
			default: return 32'h4000_0000 * $urandom_range(0, 3) + $urandom_range(0, 2);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_pos(int unsigned c);
		case ($urandom_range(0, 9))
			0:       return IDX_W'($urandom_range(0, 511));
			1:       return IDX_W'(c);
			2:       return '0;
			default: return (c == 0) ? '0 : IDX_W'($urandom_range(0, c - 1));
		endcase
	endfunction

	// grow: percent of beats that insert
	task automatic random_request(input int unsigned grow);
		logic [FUNC_BITS-1:0] f;
		if ($urandom_range(0, 99) < grow)
			f = ($urandom_range(0, 1) != 0) ? FUNC_SORTED : FUNC_INSERT;
		else
			f = FUNC_BITS'($urandom_range(FUNC_ERASE, FUNC_NONE));
		issue(f, pick_pos(sb.count), pick_value());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		issue(FUNC_GET, 9'd0, '0);
		issue(FUNC_ERASE, 9'd0, '0);
		issue(FUNC_SET, 9'd0, ITEM_MAX);
		issue(FUNC_FIND, 9'd0, '0);
		issue(FUNC_REMOVE, 9'd0, '0);
		issue(FUNC_NONE, 9'd0, '0);
		issue(FUNC_INSERT, 9'd1, 32'd3);
		// build, sorted insert before equal and past the end
		issue(FUNC_INSERT, 9'd0, 32'h8000_0000);
		issue(FUNC_SORTED, 9'd0, '0);
		issue(FUNC_SORTED, 9'd0, ITEM_MAX);
		issue(FUNC_SORTED, 9'd0, 32'h8000_0000);
		issue(FUNC_INSERT, 9'd4, 32'd7);
		issue(FUNC_INSERT, 9'd511, 32'd9);
		issue(FUNC_GET, 9'd0, '0);
		issue(FUNC_GET, 9'd4, '0);
		issue(FUNC_GET, 9'd5, '0);
		issue(FUNC_SET, 9'd4, ITEM_MAX);
		issue(FUNC_FIND, 9'd0, ITEM_MAX);
		issue(FUNC_FIND, 9'd0, 32'h0001_2345);
		issue(FUNC_ERASE, 9'd0, '0);
		issue(FUNC_ERASE, 9'd511, '0);
		issue(FUNC_REMOVE, 9'd0, ITEM_MAX);
		issue(FUNC_REMOVE, 9'd0, 32'h8000_0000);
		// insert after emptied
		issue(FUNC_SORTED, 9'd0, 32'h55);
		issue(FUNC_NONE, 9'd511, ITEM_MAX);
		drain();

		// fill to capacity, then push against the full table
		while (sb.count < TBL_DEPTH) begin
			random_request(90);
			pace();
		end
		repeat (20) begin
			random_request(90);
			pace();
		end

		repeat (150) begin
			random_request(40);
			pace();
		end
		drain();

		// one value in every entry, then remove them all
		for (int i = 0; i < sb.count; i++) begin
			issue(FUNC_SET, IDX_W'(i), FLOOD_VAL);
			pace();
		end
		while (sb.count < TBL_DEPTH) begin
			if ($urandom_range(0, 4) == 0)
				issue(FUNC_SORTED, pick_pos(sb.count), FLOOD_VAL);
			else
				issue(FUNC_INSERT, pick_pos(sb.count), FLOOD_VAL);
			pace();
		end
		issue(FUNC_SORTED, 9'd0, FLOOD_VAL);
		issue(FUNC_INSERT, 9'd0, FLOOD_VAL);
		issue(FUNC_REMOVE, 9'd0, FLOOD_VAL);
		issue(FUNC_INSERT, 9'd0, 32'd1);
		issue(FUNC_SORTED, 9'd0, 32'd2);
		issue(FUNC_FIND, 9'd0, 32'd2);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("ordered_sequence_table_core test passed");
		end else begin
			$display("ordered_sequence_table_core test failed");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("ordered_sequence_table_core test failed");
		$finish;
	end

endmodule
